### rtl/trot_gait_foot_trajectory_macros.svh
// Assertion macros shared by the trot gait foot trajectory RTL.
`ifndef TROT_GAIT_FOOT_TRAJECTORY_MACROS_SVH
`define TROT_GAIT_FOOT_TRAJECTORY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tgft assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TGFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tgft assertion failed");

`endif

### rtl/tgft_pkg.sv
// Package: constants, types and the sine table of the trot gait generator.
package tgft_pkg;

    localparam int PHASE_BITS   = 16;
    localparam int SINE_ENTRIES = 256;
    localparam int LEGS         = 4;
    localparam int LEG_W        = $clog2(LEGS);

    // Sine table index covers 0 .. 2*SINE_ENTRIES-1 before folding
    localparam int SINE_AW   = $clog2(2 * SINE_ENTRIES);
    localparam int SINE_FRAC = 15;

    // Shared multiplier geometry
    localparam int FACT_W  = PHASE_BITS + 2;   // signed x ramp factor
    localparam int DISP_SH = 12;
    localparam int DISP_W  = 21;               // signed displacement, Q.13
    localparam int PROD_W  = DISP_W + FACT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_Z      = 3'd4;

    // Register reset values
    localparam logic [15:0]        RST_PHASE_STEP  = 16'd1638;
    localparam logic [15:0]        RST_CYCLE_TIME  = 16'd1638;
    localparam logic [14:0]        RST_STEP_HEIGHT = 15'd655;
    localparam logic signed [15:0] RST_REST_X      = 16'sd0;
    localparam logic signed [15:0] RST_REST_Z      = -16'sd1638;

    // Input item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_SPEED = 1'b1;

    // Multiplier operand select
    localparam logic [1:0] MUL_DISP = 2'd0;
    localparam logic [1:0] MUL_X    = 2'd1;
    localparam logic [1:0] MUL_Z    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic             load_speed;
        logic             adv_phase;
        logic [1:0]       mul_sel;
        logic             cap_prod;
        logic             cap_sine;
        logic             load_disp;
        logic             wr_x;
        logic             wr_z;
        logic             load_out;
        logic [LEG_W-1:0] leg;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Quarter-wave sine table, Q1.15, built at elaboration by a Taylor series
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef logic [15:0] t_sine_tab [0:SINE_ENTRIES];

    // Two factors of x per series term, each product scaled back to Q2.30
    function automatic longint f_sq_step(input longint term, input longint x);
        longint r;
        r = term * x / ONE_Q30;
        r = r * x / ONE_Q30;
        return r;
    endfunction

    function automatic t_sine_tab f_sine_tab();
        t_sine_tab tab;
        longint    x;
        longint    term;
        longint    sum;
        int        k;
        for (k = 0; k <= SINE_ENTRIES; k++) begin
            x    = (PI_Q30 * k) / (2 * SINE_ENTRIES);
            sum  = x;
            // ten more odd terms after x, term i divided by (2i)(2i+1)
            term = -f_sq_step(x, x) / 64'sd6;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd20;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd42;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd72;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd110;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd156;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd210;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd272;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd342;
            sum  = sum + term;
            term = -f_sq_step(term, x) / 64'sd420;
            sum  = sum + term;
            if (sum < 0) sum = 0;
            sum = (sum + 16384) >>> 15;
            if (sum > 32768) sum = 32768;
            tab[k] = 16'(sum);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TABLE = f_sine_tab();

    // Saturate to the signed 16-bit range
    function automatic logic signed [15:0] f_sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767)       r = 16'sh7FFF;
        else if (v < -24'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

endpackage

### rtl/tgft_in_if.sv
// Input channel: tick or speed command transactions.
interface tgft_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [15:0] speed_cmd;

    modport source (output valid, output kind, output speed_cmd, input ready);
    modport sink   (input valid, input kind, input speed_cmd, output ready);
endinterface

### rtl/tgft_out_if.sv
// Output channel: foot positions and stance mask for all four legs.
interface tgft_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_left_front;
    logic signed [15:0] z_left_front;
    logic signed [15:0] x_left_back;
    logic signed [15:0] z_left_back;
    logic signed [15:0] x_right_front;
    logic signed [15:0] z_right_front;
    logic signed [15:0] x_right_back;
    logic signed [15:0] z_right_back;
    logic [3:0]         stance_mask;

    modport source (
        output valid, input ready,
        output x_left_front, output z_left_front, output x_left_back, output z_left_back,
        output x_right_front, output z_right_front, output x_right_back,
        output z_right_back, output stance_mask
    );
    modport sink (
        input valid, output ready,
        input x_left_front, input z_left_front, input x_left_back, input z_left_back,
        input x_right_front, input z_right_front, input x_right_back,
        input z_right_back, input stance_mask
    );
endinterface

### rtl/tgft_dp.sv
// Datapath: config registers, gait state, shared multiplier and result register.
module tgft_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tgft_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tgft_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic signed [15:0]               i_speed_cmd,
    input  tgft_pkg::t_dp_cmd                i_cmd,
    output tgft_pkg::t_dp_stat               o_stat,
    tgft_out_if.source                       o_result
);

    localparam int PB = tgft_pkg::PHASE_BITS;
    localparam int FW = tgft_pkg::FACT_W;
    localparam int PW = tgft_pkg::PROD_W;
    localparam int DW = tgft_pkg::DISP_W;
    localparam int SA = tgft_pkg::SINE_AW;
    localparam int LW = tgft_pkg::LEG_W;
    localparam logic signed [FW-1:0] ONE_F = {2'b01, {PB{1'b0}}};
    localparam logic [PB-1:0]        HALF  = {1'b1, {(PB-1){1'b0}}};

    // Configuration and gait state
    logic [15:0]        r_phase_step;
    logic [15:0]        r_cycle_time;
    logic [14:0]        r_step_height;
    logic signed [15:0] r_rest_x;
    logic signed [15:0] r_rest_z;
    logic [PB-1:0]      r_phase;
    logic signed [15:0] r_speed;

    // Working registers
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_disp;
    logic [15:0]          r_sine;
    logic signed [15:0]   r_x [0:tgft_pkg::LEGS-1];
    logic signed [15:0]   r_z [0:tgft_pkg::LEGS-1];
    logic [tgft_pkg::LEGS-1:0] r_stance;

    // Result register
    logic signed [15:0]   r_ox [0:tgft_pkg::LEGS-1];
    logic signed [15:0]   r_oz [0:tgft_pkg::LEGS-1];
    logic [tgft_pkg::LEGS-1:0] r_ostance;
    logic                 r_out_valid;

    logic signed [15:0]   n_speed;
    logic [PB-1:0]        cur_phase;
    logic                 swing;
    logic [PB:0]          four_l;
    logic signed [FW-1:0] fact;
    logic [PB-1:0]        t_val;
    logic [PB+SA-1:0]     t_scaled;
    logic [SA-1:0]        sine_pos;
    logic [SA-1:0]        sine_idx;
    logic signed [DW-1:0] mul_a;
    logic signed [FW-1:0] mul_b;
    logic signed [23:0]   x_sum;
    logic signed [23:0]   z_sum;
    logic [15:0]          z_lift;

    // Negated speed command, the most negative value saturates
    assign n_speed = (i_speed_cmd == 16'sh8000) ? 16'sh7FFF : -i_speed_cmd;

    // Leg phase: legs lf and rb use the gait phase, lb and rf are half a cycle off
    always_comb begin
        if (i_cmd.leg == '0 || i_cmd.leg == LW'(tgft_pkg::LEGS - 1)) begin
            cur_phase = r_phase;
        end else begin
            cur_phase = r_phase + HALF;
        end
    end

    assign swing  = ~cur_phase[PB-1];
    assign four_l = {cur_phase[PB-2:0], 2'b00};
    assign fact   = swing ? (signed'(FW'(four_l)) - ONE_F) : (ONE_F - signed'(FW'(four_l)));

    // Sine table position of t = 2 * swing fraction, folded onto the quarter wave
    assign t_val    = {cur_phase[PB-2:0], 1'b0};
    assign t_scaled = (PB+SA)'(t_val) * (PB+SA)'(2 * tgft_pkg::SINE_ENTRIES);
    assign sine_pos = t_scaled[PB+SA-1:PB];
    always_comb begin
        if ({1'b0, sine_pos} <= (SA+1)'(tgft_pkg::SINE_ENTRIES)) begin
            sine_idx = sine_pos;
        end else begin
            sine_idx = SA'((SA+1)'(2 * tgft_pkg::SINE_ENTRIES) - {1'b0, sine_pos});
        end
    end

    // Shared multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            tgft_pkg::MUL_DISP: begin
                mul_a = DW'(r_speed);
                mul_b = signed'(FW'(r_cycle_time));
            end
            tgft_pkg::MUL_X: begin
                mul_a = r_disp;
                mul_b = fact;
            end
            tgft_pkg::MUL_Z: begin
                mul_a = signed'(DW'(r_step_height));
                mul_b = signed'(FW'(r_sine));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Position sums
    assign x_sum  = 24'(signed'(r_prod[PW-1:PB])) + 24'(r_rest_x);
    assign z_lift = r_prod[tgft_pkg::SINE_FRAC+15:tgft_pkg::SINE_FRAC];
    assign z_sum  = 24'(r_rest_z) + signed'(24'(z_lift));

    // Configuration registers and gait state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= tgft_pkg::RST_PHASE_STEP;
            r_cycle_time  <= tgft_pkg::RST_CYCLE_TIME;
            r_step_height <= tgft_pkg::RST_STEP_HEIGHT;
            r_rest_x      <= tgft_pkg::RST_REST_X;
            r_rest_z      <= tgft_pkg::RST_REST_Z;
            r_phase       <= '0;
            r_speed       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tgft_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data;
                    tgft_pkg::CFG_CYCLE_TIME:  r_cycle_time  <= i_cfg_data;
                    tgft_pkg::CFG_STEP_HEIGHT: r_step_height <= i_cfg_data[14:0];
                    tgft_pkg::CFG_REST_X:      r_rest_x      <= signed'(i_cfg_data);
                    tgft_pkg::CFG_REST_Z:      r_rest_z      <= signed'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.load_speed) r_speed <= n_speed;
            if (i_cmd.adv_phase)  r_phase <= r_phase + PB'(r_phase_step);
        end
    end

    // Arithmetic working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_prod)  r_prod <= PW'(mul_a) * PW'(mul_b);
        if (i_cmd.load_disp) r_disp <= r_prod[tgft_pkg::DISP_SH+DW-1:tgft_pkg::DISP_SH];
        if (i_cmd.cap_sine)  r_sine <= tgft_pkg::SINE_TABLE[sine_idx];
        if (i_cmd.wr_x) begin
            r_x[i_cmd.leg]      <= tgft_pkg::f_sat16(x_sum);
            r_stance[i_cmd.leg] <= ~swing;
        end
        if (i_cmd.wr_z) begin
            r_z[i_cmd.leg] <= swing ? tgft_pkg::f_sat16(z_sum) : r_rest_z;
        end
    end

    // Result register, frees the work registers for the next tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ox      <= r_x;
            r_oz      <= r_z;
            r_ostance <= r_stance;
        end
    end

    assign o_stat.out_free = ~r_out_valid | o_result.ready;

    assign o_result.valid         = r_out_valid;
    assign o_result.x_left_front  = r_ox[0];
    assign o_result.z_left_front  = r_oz[0];
    assign o_result.x_left_back   = r_ox[1];
    assign o_result.z_left_back   = r_oz[1];
    assign o_result.x_right_front = r_ox[2];
    assign o_result.z_right_front = r_oz[2];
    assign o_result.x_right_back  = r_ox[3];
    assign o_result.z_right_back  = r_oz[3];
    assign o_result.stance_mask   = r_ostance;

endmodule

### rtl/tgft_ctrl.sv
// Controller: sequences one tick through the shared multiplier, leg by leg.
`include "trot_gait_foot_trajectory_macros.svh"

module tgft_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tgft_in_if.sink            i_item,
    input  tgft_pkg::t_dp_stat i_stat,
    output tgft_pkg::t_dp_cmd  o_cmd
);

    localparam int LW = tgft_pkg::LEG_W;
    localparam logic [LW-1:0] LAST_LEG = LW'(tgft_pkg::LEGS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_DISPW = 3'd2;
    localparam logic [2:0] S_XMUL  = 3'd3;
    localparam logic [2:0] S_XWR   = 3'd4;
    localparam logic [2:0] S_ZMUL  = 3'd5;
    localparam logic [2:0] S_ZWR   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [LW-1:0] r_leg;
    logic [LW-1:0] n_leg;
    logic          tick_acc;

    assign i_item.ready = (r_state == S_IDLE);
    assign tick_acc     = i_item.valid && i_item.ready && (i_item.kind == tgft_pkg::KIND_TICK);

    // Next state and command decode
    always_comb begin
        n_state       = r_state;
        n_leg         = r_leg;
        o_cmd         = '0;
        o_cmd.leg     = r_leg;
        o_cmd.mul_sel = tgft_pkg::MUL_DISP;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    if (i_item.kind == tgft_pkg::KIND_SPEED) begin
                        o_cmd.load_speed = 1'b1;
                    end else begin
                        o_cmd.adv_phase = 1'b1;
                        n_state         = S_DISP;
                    end
                end
            end
            S_DISP: begin
                o_cmd.mul_sel  = tgft_pkg::MUL_DISP;
                o_cmd.cap_prod = 1'b1;
                n_state        = S_DISPW;
            end
            S_DISPW: begin
                o_cmd.load_disp = 1'b1;
                n_leg           = '0;
                n_state         = S_XMUL;
            end
            S_XMUL: begin
                o_cmd.mul_sel  = tgft_pkg::MUL_X;
                o_cmd.cap_prod = 1'b1;
                o_cmd.cap_sine = 1'b1;
                n_state        = S_XWR;
            end
            S_XWR: begin
                o_cmd.wr_x = 1'b1;
                n_state    = S_ZMUL;
            end
            S_ZMUL: begin
                o_cmd.mul_sel  = tgft_pkg::MUL_Z;
                o_cmd.cap_prod = 1'b1;
                n_state        = S_ZWR;
            end
            S_ZWR: begin
                o_cmd.wr_z = 1'b1;
                if (r_leg == LAST_LEG) begin
                    n_state = S_OUT;
                end else begin
                    n_leg   = r_leg + 1'b1;
                    n_state = S_XMUL;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_leg   <= '0;
        end else begin
            r_state <= n_state;
            r_leg   <= n_leg;
        end
    end

    // A result never overwrites one still waiting downstream
    `TGFT_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_stat.out_free)
    // An accepted tick starts the displacement multiply
    `TGFT_ASSERT_NXT(a_tick_start, i_clk, i_rst_n, tick_acc, r_state == S_DISP)
    // A blocked result holds the sequencer in place
    `TGFT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT) && !i_stat.out_free,
        r_state == S_OUT)

endmodule

### rtl/trot_gait_foot_trajectory.sv
// Top level of the trot gait foot trajectory generator.
//
// Input channel i_item carries transactions of two kinds. A speed command
// (kind = 1) stores the negated, saturated speed and produces no result. A
// tick (kind = 0) advances the gait phase and produces one result on
// o_result: x and z of all four feet and the stance mask. The configuration
// write port (i_cfg_we, i_cfg_idx, i_cfg_data) sets phase step, cycle time,
// step height, rest x and rest z; write only while idle.
// A tick runs one displacement multiply, then two multiplies and two
// write-backs per leg on the single shared multiplier, before the result
// register is loaded. One item is in work at a time, so a new tick is
// accepted only once the previous one has reached the result register.
// The result register decouples the output: a new tick is accepted while a
// result still waits, and the sequencer only holds in its last step when the
// receiver has not taken the previous result.
// Reset (synchronous, active low) clears phase and speed, loads the default
// configuration and empties the result register.
module trot_gait_foot_trajectory (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tgft_in_if.sink                         i_item,
    tgft_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [tgft_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tgft_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tgft_pkg::t_dp_cmd  dp_cmd;
    tgft_pkg::t_dp_stat dp_stat;

    // Sequencer
    tgft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Arithmetic and result register
    tgft_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_speed_cmd (i_item.speed_cmd),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_result    (o_result)
    );

endmodule
